// ===== design/mufc_pkg.sv =====
// Shared types, codes and constants of the meter UART frame codec.
package mufc_pkg;

	localparam logic [7:0]  FRAME_HEADER = 8'hA5;
	localparam logic [15:0] SHORT_LIMIT  = 16'h00FF;
	localparam logic [2:0]  MAX_REPLY    = 3'd4;
	localparam int          MAX_WORDS    = 5;
	localparam int          CNT_W        = $clog2(MAX_WORDS + 1);

	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_RX      = 2'd2;
	localparam logic [1:0] OP_TIMEOUT = 2'd3;

	localparam logic KIND_TX   = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  register_address;
		logic [15:0] write_data;
		logic [2:0]  reply_size;
		logic [7:0]  rx_byte;
	} item_t;

	// Results of one item: up to MAX_WORDS tx bytes, or one read result.
	typedef struct packed {
		logic                      kind;
		logic [MAX_WORDS-1:0][7:0] bytes;
		logic [CNT_W-1:0]          count;
		logic [31:0]               value;
		logic                      ok;
	} frame_t;

endpackage

// ===== design/mufc_ifs.sv =====
// Valid/ready channel interfaces for the codec's request and response words.
interface mufc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [7:0]  register_address;
	logic [15:0] write_data;
	logic [2:0]  reply_size;
	logic [7:0]  rx_byte;

	modport source (output valid, opcode, register_address, write_data, reply_size, rx_byte,
		input ready);
	modport sink (input valid, opcode, register_address, write_data, reply_size, rx_byte,
		output ready);
endinterface

interface mufc_rsp_if;
	logic        valid;
	logic        ready;
	logic        out_kind;
	logic [7:0]  tx_byte;
	logic [31:0] read_value;
	logic        read_ok;
	logic        last_of_run;

	modport source (output valid, out_kind, tx_byte, read_value, read_ok, last_of_run,
		input ready);
	modport sink (input valid, out_kind, tx_byte, read_value, read_ok, last_of_run,
		output ready);
endinterface

// ===== design/mufc_engine.sv =====
// Protocol state and frame building for one registered request word.
module mufc_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  mufc_pkg::item_t item,
	output mufc_pkg::frame_t frame
);
	import mufc_pkg::*;

	logic        pending_q;
	logic [2:0]  expected_q;
	logic [2:0]  seen_q;
	logic [39:0] acc_q;
	logic [7:0]  sum_q;

	logic        pending_d;
	logic [2:0]  expected_d;
	logic [2:0]  seen_d;
	logic [39:0] acc_d;
	logic [7:0]  sum_d;

	logic [2:0]  size_sat;
	logic [7:0]  wr_sum;
	logic [2:0]  rx_seen;
	logic [39:0] rx_acc;
	logic [7:0]  rx_sum;
	logic        fin;
	logic [2:0]  fin_seen;
	logic [39:0] fin_acc;
	logic [7:0]  fin_sum;

	always_comb begin
		pending_d  = pending_q;
		expected_d = expected_q;
		seen_d     = seen_q;
		acc_d      = acc_q;
		sum_d      = sum_q;
		frame      = '0;
		fin        = 1'b0;
		fin_seen   = seen_q;
		fin_acc    = acc_q;
		fin_sum    = sum_q;

		size_sat = (item.reply_size > MAX_REPLY) ? MAX_REPLY : item.reply_size;
		wr_sum   = FRAME_HEADER + item.register_address;
		rx_sum   = (seen_q != 3'd0) ? sum_q + acc_q[7:0] : sum_q;
		rx_acc   = {acc_q[31:0], item.rx_byte};
		rx_seen  = seen_q + 3'd1;

		unique case (item.opcode)
			OP_WRITE: begin
				frame.kind     = KIND_TX;
				frame.bytes[0] = FRAME_HEADER;
				frame.bytes[1] = item.register_address;
				frame.count    = CNT_W'(2);
				if (item.write_data != 16'd0) begin
					if (item.write_data < SHORT_LIMIT) begin
						frame.bytes[2] = item.write_data[7:0];
						frame.bytes[3] = ~(wr_sum + item.write_data[7:0]);
						frame.count    = CNT_W'(4);
					end else begin
						frame.bytes[2] = item.write_data[15:8];
						frame.bytes[3] = item.write_data[7:0];
						frame.bytes[4] = ~(wr_sum + item.write_data[15:8] +
							item.write_data[7:0]);
						frame.count    = CNT_W'(5);
					end
				end
			end
			OP_READ: begin
				pending_d      = 1'b1;
				expected_d     = size_sat + 3'd1;
				seen_d         = 3'd0;
				acc_d          = '0;
				sum_d          = wr_sum;
				frame.kind     = KIND_TX;
				frame.bytes[0] = FRAME_HEADER;
				frame.bytes[1] = item.register_address;
				frame.count    = CNT_W'(2);
			end
			OP_RX: begin
				if (pending_q) begin
					seen_d   = rx_seen;
					acc_d    = rx_acc;
					sum_d    = rx_sum;
					fin_seen = rx_seen;
					fin_acc  = rx_acc;
					fin_sum  = rx_sum;
					fin      = (rx_seen >= expected_q);
				end
			end
			OP_TIMEOUT: begin
				fin = pending_q;
			end
			default: begin
			end
		endcase

		// Completed read: one result word, state back to idle.
		if (fin) begin
			frame.kind  = KIND_READ;
			frame.count = CNT_W'(1);
			if (fin_seen != 3'd0) begin
				frame.value = fin_acc[39:8];
				frame.ok    = (~fin_sum == fin_acc[7:0]);
			end
			pending_d  = 1'b0;
			expected_d = 3'd0;
			seen_d     = 3'd0;
			acc_d      = '0;
			sum_d      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= 1'b0;
			expected_q <= 3'd0;
			seen_q     <= 3'd0;
			acc_q      <= '0;
			sum_q      <= '0;
		end else if (take) begin
			pending_q  <= pending_d;
			expected_q <= expected_d;
			seen_q     <= seen_d;
			acc_q      <= acc_d;
			sum_q      <= sum_d;
		end
	end

endmodule

// ===== design/mufc_outq.sv =====
// Result register that holds one frame and hands it out one word per cycle while rsp.ready is high.
module mufc_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  mufc_pkg::frame_t frame,
	output logic             free,
	mufc_rsp_if.source       rsp
);
	import mufc_pkg::*;

	logic                      kind_q;
	logic [MAX_WORDS-1:0][7:0] bytes_q;
	logic [31:0]               value_q;
	logic                      ok_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          idx_q;

	logic busy;
	logic fire;
	logic last;

	assign busy = (count_q != '0);
	assign fire = busy && rsp.ready;
	assign last = (idx_q == count_q - CNT_W'(1));
	assign free = !busy || (fire && last);

	assign rsp.valid       = busy;
	assign rsp.out_kind    = kind_q;
	assign rsp.tx_byte     = (kind_q == KIND_TX) ? bytes_q[idx_q] : 8'd0;
	assign rsp.read_value  = (kind_q == KIND_READ) ? value_q : 32'd0;
	assign rsp.read_ok     = (kind_q == KIND_READ) ? ok_q : 1'b0;
	assign rsp.last_of_run = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else if (load && frame.count != '0) begin
			count_q <= frame.count;
			idx_q   <= '0;
		end else if (fire) begin
			if (last) begin
				count_q <= '0;
				idx_q   <= '0;
			end else begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && frame.count != '0) begin
			kind_q  <= frame.kind;
			bytes_q <= frame.bytes;
			value_q <= frame.value;
			ok_q    <= frame.ok;
		end
	end

endmodule

// ===== design/meter_uart_frame_codec.sv =====
// Top level of the meter UART frame codec: request register, engine, result queue.
// A word accepted on req goes into the request register; once the result queue is
// free, its frame is loaded into the result register and its first word is on rsp.
// Throughput: one request word per cycle when it gives zero or one result and rsp
// is not stalled; a write or read request waits for the result queue to hand out
// its frame of 2 to 5 bytes, one word per cycle while rsp.ready is high.
// Reset (arst_n low, asynchronous): no read pending, all reply state cleared.
module meter_uart_frame_codec (
	input  logic        clk,
	input  logic        arst_n,
	mufc_req_if.sink    req,
	mufc_rsp_if.source  rsp
);
	import mufc_pkg::*;

	// Request register: holds one word until the result queue can take its frame.
	item_t item_s1;
	logic  valid_s1;

	frame_t frame;
	logic   free;
	logic   take;
	logic   accept;

	// The engine commits its state update in the same cycle the frame is loaded,
	// so state and queued results always move together.
	assign take      = valid_s1 && free;
	assign req.ready = !valid_s1 || take;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !take);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.opcode           <= req.opcode;
			item_s1.register_address <= req.register_address;
			item_s1.write_data       <= req.write_data;
			item_s1.reply_size       <= req.reply_size;
			item_s1.rx_byte          <= req.rx_byte;
		end
	end

	// Frame building and reply collection.
	mufc_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item_s1),
		.frame  (frame)
	);

	// Result queue: an item giving no results just passes through take.
	mufc_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (take),
		.frame  (frame),
		.free   (free),
		.rsp    (rsp)
	);

endmodule

// ===== dv/mufc_frame_checker.sv =====
`timescale 1ns / 1ps
// Checker for the frame codec: watches both channels, predicts result words and compares them.
module mufc_frame_checker (
	input  logic clk,
	input  logic arst_n,
	mufc_req_if  req,
	mufc_rsp_if  rsp,
	output int   mismatches,
	output int   words_due
);
	import mufc_pkg::*;

	typedef struct packed {
		logic        kind;
		logic [7:0]  tx;
		logic [31:0] value;
		logic        ok;
		logic        last;
	} result_word_t;

	result_word_t due_q[$];
	result_word_t want;
	item_t        seen_item;

	// reply collection state
	logic        rd_armed;
	logic [2:0]  rd_need;
	logic [2:0]  rd_got;
	logic [39:0] rd_shift;
	logic [7:0]  rd_sum;
	int          fails = 0;

	assign mismatches = fails;

	function automatic void queue_word(logic kind, logic [7:0] tx, logic [31:0] value,
		logic ok, logic last);
		result_word_t w;
		w = '{kind, tx, value, ok, last};
		due_q.push_back(w);
	endfunction

	// Last byte seen is the checksum, the ones before it the data.
	function automatic void close_read();
		logic [31:0] value;
		logic        ok;
		value = '0;
		ok    = 1'b0;
		if (rd_got != 3'd0) begin
			value = rd_shift[39:8];
			ok    = (~rd_sum == rd_shift[7:0]);
		end
		queue_word(KIND_READ, 8'h00, value, ok, 1'b1);
		rd_armed = 1'b0;
		rd_got   = '0;
		rd_need  = '0;
		rd_shift = '0;
		rd_sum   = '0;
	endfunction

	function automatic void predict_words(item_t it);
		logic [7:0] frame [5];
		logic [7:0] sum;
		logic [2:0] sz;
		int         n;
		case (it.opcode)
		OP_WRITE: begin
			frame[0] = FRAME_HEADER;
			frame[1] = it.register_address;
			n = 2;
			if (it.write_data != 16'h0000) begin
				if (it.write_data < SHORT_LIMIT) begin
					frame[2] = it.write_data[7:0];
					n = 3;
				end else begin
					frame[2] = it.write_data[15:8];
					frame[3] = it.write_data[7:0];
					n = 4;
				end
				sum = 8'h00;
				for (int i = 0; i < n; i++)
					sum = sum + frame[i];
				frame[n] = ~sum;
				n++;
			end
			for (int i = 0; i < n; i++)
				queue_word(KIND_TX, frame[i], '0, 1'b0, i == n - 1);
		end
		OP_READ: begin
			sz = (it.reply_size > MAX_REPLY) ? MAX_REPLY : it.reply_size;
			rd_armed = 1'b1;
			rd_need  = sz + 3'd1;
			rd_got   = '0;
			rd_shift = '0;
			rd_sum   = FRAME_HEADER + it.register_address;
			queue_word(KIND_TX, FRAME_HEADER, '0, 1'b0, 1'b0);
			queue_word(KIND_TX, it.register_address, '0, 1'b0, 1'b1);
		end
		OP_RX: begin
			if (rd_armed) begin
				if (rd_got != 3'd0)
					rd_sum = rd_sum + rd_shift[7:0];
				rd_shift = {rd_shift[31:0], it.rx_byte};
				rd_got   = rd_got + 3'd1;
				if (rd_got >= rd_need)
					close_read();
			end
		end
		default: begin
			if (rd_armed)
				close_read();
		end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_armed = 1'b0;
			rd_need  = '0;
			rd_got   = '0;
			rd_shift = '0;
			rd_sum   = '0;
			due_q.delete();
			words_due <= 0;
		end else begin
			if (req.valid && req.ready) begin
				seen_item = '{req.opcode, req.register_address, req.write_data,
					req.reply_size, req.rx_byte};
				predict_words(seen_item);
			end
			if (rsp.valid && rsp.ready) begin
				if (due_q.size() == 0) begin
					$error("result word with none due: kind %0d tx %02h value %08h ok %0d",
						rsp.out_kind, rsp.tx_byte, rsp.read_value, rsp.read_ok);
					fails++;
				end else begin
					want = due_q.pop_front();
					if (rsp.out_kind !== want.kind) begin
						$error("out_kind: expected %0d, got %0d", want.kind, rsp.out_kind);
						fails++;
					end
					if (rsp.tx_byte !== want.tx) begin
						$error("tx_byte: expected %02h, got %02h", want.tx, rsp.tx_byte);
						fails++;
					end
					if (rsp.read_value !== want.value) begin
						$error("read_value: expected %08h, got %08h", want.value,
							rsp.read_value);
						fails++;
					end
					if (rsp.read_ok !== want.ok) begin
						$error("read_ok: expected %0d, got %0d", want.ok, rsp.read_ok);
						fails++;
					end
					if (rsp.last_of_run !== want.last) begin
						$error("last_of_run: expected %0d, got %0d", want.last,
							rsp.last_of_run);
						fails++;
					end
				end
			end
			words_due <= due_q.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the frame codec: stimulus, receiver stalls, watchdog and verdict.
module tb;
	import mufc_pkg::*;

	localparam int ITEM_TARGET   = 300;
	localparam int QUIET_LIMIT   = 5000;  // cycles without any accepted word
	localparam int SETTLE_CYCLES = 8;     // margin after the final drain

	// how a read transaction's reply is shaped
	localparam int REPLY_GOOD = 0;
	localparam int REPLY_BAD  = 1;  // checksum byte corrupted
	localparam int REPLY_CUT  = 2;  // ends early on a timeout word

	// receiver stall modes
	localparam int RX_OPEN   = 0;
	localparam int RX_COIN   = 1;
	localparam int RX_CHOKE  = 2;
	localparam int RX_TOGGLE = 3;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   words_due;
	int   quiet_cycles = 0;
	int   burst_left;
	int   items_sent;

	mufc_req_if req();
	mufc_rsp_if rsp();

	meter_uart_frame_codec DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	mufc_frame_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.mismatches (mismatches),
		.words_due  (words_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake on either side shows up as a long quiet stretch.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	// Receiver: switches between stall modes at random spans, so stalls land on every
	// byte position of a frame, with fully open stretches in between.
	initial begin
		int mode;
		int span;
		rsp.ready <= 1'b0;
		forever begin
			mode = $urandom_range(RX_OPEN, RX_TOGGLE);
			span = $urandom_range(8, 64);
			repeat (span) begin
				@(posedge clk);
				case (mode)
				RX_OPEN:  rsp.ready <= 1'b1;
				RX_COIN:  rsp.ready <= 1'($urandom_range(0, 1));
				RX_CHOKE: rsp.ready <= ($urandom_range(0, 3) == 0);
				default:  rsp.ready <= ~rsp.ready;
				endcase
			end
		end
	end

	// Mix of zero, one-byte, the 0xFF boundary and two-byte data words.
	function automatic logic [15:0] pick_write_data();
		case ($urandom_range(0, 5))
		0:       return 16'h0000;
		1:       return 16'($urandom_range(1, 254));
		2:       return SHORT_LIMIT;
		3:       return 16'($urandom_range(256, 65535));
		default: return 16'($urandom);
		endcase
	endfunction

	// Drive one request word and hold it until accepted. A new burst starts with
	// a random gap (sometimes none); valid stays high across words of a burst.
	task automatic send(input logic [1:0] op, input logic [7:0] addr,
		input logic [15:0] data, input logic [2:0] size, input logic [7:0] rxb);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		req.valid            <= 1'b1;
		req.opcode           <= op;
		req.register_address <= addr;
		req.write_data       <= data;
		req.reply_size       <= size;
		req.rx_byte          <= rxb;
		do @(posedge clk); while (!req.ready);
		burst_left--;
		items_sent++;
	endtask

	// Read request followed by its reply bytes. Sizes above the maximum still get
	// only the saturated number of data bytes. With mix set, writes may slip in
	// while the reply is being collected.
	task automatic read_txn(input logic [7:0] addr, input logic [2:0] size,
		input int style, input bit mix);
		int         n;
		int         k;
		logic [7:0] sum;
		logic [7:0] b;
		n   = int'((size > MAX_REPLY) ? MAX_REPLY : size);
		sum = FRAME_HEADER + addr;
		send(OP_READ, addr, 16'($urandom), size, 8'($urandom));
		k = (style == REPLY_CUT) ? $urandom_range(0, n) : n;
		for (int i = 0; i < k; i++) begin
			if (mix && $urandom_range(0, 7) == 0)
				send(OP_WRITE, 8'($urandom), pick_write_data(), 3'($urandom),
					8'($urandom));
			b   = 8'($urandom);
			sum = sum + b;
			send(OP_RX, 8'($urandom), 16'($urandom), 3'($urandom), b);
		end
		if (style == REPLY_CUT) begin
			send(OP_TIMEOUT, 8'($urandom), 16'($urandom), 3'($urandom), 8'($urandom));
		end else begin
			b = (style == REPLY_BAD) ? 8'($urandom_range(1, 255)) : 8'h00;
			send(OP_RX, 8'($urandom), 16'($urandom), 3'($urandom), ~sum ^ b);
		end
	endtask

	// Sender holds off until every predicted word has come out.
	task automatic drain();
		req.valid <= 1'b0;
		do @(posedge clk); while (words_due != 0);
		burst_left = 0;
	endtask

	initial begin
		int pick;
		int style;
		bit paused;
		arst_n               <= 1'b0;
		req.valid            <= 1'b0;
		req.opcode           <= OP_WRITE;
		req.register_address <= '0;
		req.write_data       <= '0;
		req.reply_size       <= '0;
		req.rx_byte          <= '0;
		burst_left = 0;
		items_sent = 0;
		paused     = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// writes: no data, smallest one-byte, largest one-byte, 0xFF goes two-byte, max
		send(OP_WRITE, 8'h00, 16'h0000, 3'd0, 8'h00);
		send(OP_WRITE, 8'hFF, 16'h0001, 3'd7, 8'hFF);
		send(OP_WRITE, 8'h3C, 16'h00FE, 3'd0, 8'h00);
		send(OP_WRITE, 8'hC3, SHORT_LIMIT, 3'd0, 8'h00);
		send(OP_WRITE, 8'hFF, 16'hFFFF, 3'd0, 8'h00);
		// received byte and timeout with no read pending: both dropped silently
		send(OP_RX, 8'h00, 16'h0000, 3'd0, 8'hFF);
		send(OP_TIMEOUT, 8'h00, 16'h0000, 3'd0, 8'h00);
		// zero size: reply is the checksum alone
		read_txn(8'h08, 3'd0, REPLY_GOOD, 1'b0);
		// oversized request saturates to four data bytes
		read_txn(8'hFF, 3'd7, REPLY_GOOD, 1'b0);
		// timeout before any reply byte
		send(OP_READ, 8'h11, 16'h0000, 3'd1, 8'h00);
		send(OP_TIMEOUT, 8'h00, 16'h0000, 3'd0, 8'h00);
		// timeout after some bytes: last one is taken as the checksum
		send(OP_READ, 8'h22, 16'h0000, 3'd2, 8'h00);
		send(OP_RX, 8'h00, 16'h0000, 3'd0, 8'h00);
		send(OP_RX, 8'h00, 16'h0000, 3'd0, 8'hFF);
		send(OP_TIMEOUT, 8'h00, 16'h0000, 3'd0, 8'h00);
		// new read while one is half collected: the old one is dropped
		send(OP_READ, 8'h33, 16'h0000, 3'd3, 8'h00);
		send(OP_RX, 8'h00, 16'h0000, 3'd0, 8'h12);
		read_txn(8'h44, 3'd0, REPLY_BAD, 1'b0);
		// write in the middle of a reply leaves the read alone
		send(OP_READ, 8'h55, 16'h0000, 3'd1, 8'h00);
		send(OP_WRITE, 8'hAA, 16'h8000, 3'd0, 8'h00);
		send(OP_RX, 8'h00, 16'h0000, 3'd0, 8'h7E);
		send(OP_RX, 8'h00, 16'h0000, 3'd0, ~(FRAME_HEADER + 8'h55 + 8'h7E));
		drain();

		// --- random: mostly well-formed read transactions, plus writes and noise ---
		items_sent = 0;
		while (items_sent < ITEM_TARGET) begin
			pick  = $urandom_range(0, 99);
			style = $urandom_range(0, 19);
			style = (style < 14) ? REPLY_GOOD : (style < 17) ? REPLY_BAD : REPLY_CUT;
			if (pick < 50) begin
				read_txn(8'($urandom), 3'($urandom_range(0, 7)), style, 1'b1);
			end else if (pick < 75) begin
				send(OP_WRITE, 8'($urandom), pick_write_data(), 3'($urandom),
					8'($urandom));
			end else if (pick < 85) begin
				send(OP_RX, 8'($urandom), 16'($urandom), 3'($urandom), 8'($urandom));
			end else if (pick < 92) begin
				send(OP_TIMEOUT, 8'($urandom), 16'($urandom), 3'($urandom),
					8'($urandom));
			end else begin
				// abandoned request, overtaken by a fresh one
				send(OP_READ, 8'($urandom), 16'($urandom), 3'($urandom), 8'($urandom));
				read_txn(8'($urandom), 3'($urandom_range(0, 7)), style, 1'b1);
			end
			// one full hold-off midway, so the block runs dry mid-stream
			if (!paused && items_sent >= ITEM_TARGET / 2) begin
				drain();
				paused = 1'b1;
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
